@@ sv/wildcard_vector_first_fit_grouper_macros.svh @@
// Assertion helpers for the grouper. Both expect clk and rst_n in scope.
`ifndef WILDCARD_VECTOR_FIRST_FIT_GROUPER_MACROS_SVH
`define WILDCARD_VECTOR_FIRST_FIT_GROUPER_MACROS_SVH

`ifndef NO_ASSERTIONS
// cond must never hold outside reset
`define WVFG_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
// ante in a cycle requires cons in the same cycle
`define WVFG_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define WVFG_ASSERT_NEVER(lbl, cond, msg)
`define WVFG_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

@@ sv/wvfg_pkg.sv @@
package wvfg_pkg;

  // element and wildcard encoding
  localparam int unsigned ELEM_W   = 16;
  localparam logic [15:0] WILDCARD = 16'hFFFF;

  // port field widths
  localparam int unsigned CFG_W    = 6;
  localparam int unsigned GRP_W    = 6;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned TDATA_W  = 32;

  // wide enough for any lane count or active length
  localparam int unsigned LEN_W    = 9;

  localparam logic [5:0] LENGTH_AT_RESET = 6'd48;

  // command and result kind codes (carried on tuser)
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_READ    = 1'b1;
  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef logic [ELEM_W-1:0] elem_t;

  // one result beat
  typedef struct packed {
    logic             kind;
    logic [GRP_W-1:0] group;
    logic             opened;
    logic             full;
    elem_t            value;
    logic             bad;
  } res_t;

endpackage

@@ sv/wvfg_ram.sv @@
module wvfg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/wvfg_row_unit.sv @@
module wvfg_row_unit #(
  parameter int unsigned VECTOR_LEN = 48
) (
  input  logic [VECTOR_LEN*wvfg_pkg::ELEM_W-1:0] row_i,
  input  logic [VECTOR_LEN*wvfg_pkg::ELEM_W-1:0] pend_i,
  input  logic [wvfg_pkg::LEN_W-1:0]             len_i,
  output logic                                   fit_o,
  output logic [VECTOR_LEN*wvfg_pkg::ELEM_W-1:0] merged_o,
  output logic [VECTOR_LEN*wvfg_pkg::ELEM_W-1:0] fresh_o
);

  localparam int unsigned EW = wvfg_pkg::ELEM_W;

  logic [VECTOR_LEN-1:0] lane_ok;

  // per lane: conflict test, sharpening and the row for a new group
  for (genvar i = 0; i < VECTOR_LEN; i++) begin : g_lane
    wvfg_pkg::elem_t a;
    wvfg_pkg::elem_t b;
    logic            on;
    assign a  = row_i[i*EW +: EW];
    assign b  = pend_i[i*EW +: EW];
    assign on = wvfg_pkg::LEN_W'(i) < len_i;
    assign lane_ok[i] = !on || (a == wvfg_pkg::WILDCARD) ||
                        (b == wvfg_pkg::WILDCARD) || (a == b);
    assign merged_o[i*EW +: EW] = (on && a == wvfg_pkg::WILDCARD) ? b : a;
    assign fresh_o[i*EW +: EW]  = on ? b : wvfg_pkg::WILDCARD;
  end

  assign fit_o = &lane_ok;

endmodule

@@ sv/wildcard_vector_first_fit_grouper.sv @@
// Wildcard vector first-fit grouper. Vectors arrive one element per load beat;
// 65535 is a wildcard. After the last element the templates, one row per
// entry of a single row-wide synchronous memory, are scanned one row per
// cycle from group 0: the vector is merged into the first template it does
// not contradict, otherwise it opens a new group (or reports the table full).
// The scan is paced by the memory read port: each row read is tested when its
// data returns, and the assignment beat waits in the result register until
// the output register is free. A read beat returns one template element, read
// from the memory and registered in S_RDWAIT; a group or position out of use
// skips the memory read and is flagged bad_read. Template storage is not
// initialised; no clearing pass runs after reset. Writing vector_length drops
// a partly loaded vector.
`include "wildcard_vector_first_fit_grouper_macros.svh"

module wildcard_vector_first_fit_grouper #(
  parameter int unsigned MAX_GROUPS = 64,
  parameter int unsigned VECTOR_LEN = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration: vector_length
  input  logic                          cfg_wr_en,
  input  logic [wvfg_pkg::CFG_W-1:0]    cfg_wr_data,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [15:0] element_value, [21:16] read_group, [27:22] read_position
  input  logic [wvfg_pkg::TDATA_W-1:0]  in_tdata,
  // [0] command
  input  logic                          in_tuser,
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [5:0] group_index, [6] opened_new_group, [7] table_full,
  // [23:8] read_value, [24] bad_read
  output logic [wvfg_pkg::TDATA_W-1:0]  out_tdata,
  // [0] result_kind
  output logic                          out_tuser
);

  localparam int unsigned EW     = wvfg_pkg::ELEM_W;
  localparam int unsigned LW     = wvfg_pkg::LEN_W;
  localparam int unsigned ROW_W  = VECTOR_LEN * EW;
  localparam int unsigned CNT_W  = $clog2(MAX_GROUPS + 1);
  localparam int unsigned AW     = MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned PW     = VECTOR_LEN > 1 ? $clog2(VECTOR_LEN) : 1;
  localparam int unsigned CMP_W  = CNT_W + wvfg_pkg::GRP_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RDWAIT = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [wvfg_pkg::CFG_W-1:0] vl_r, vl_nxt;
  logic [PW-1:0]              pos_r, pos_nxt;
  logic [ROW_W-1:0]           pend_r, pend_nxt;
  logic [CNT_W-1:0]           groups_r, groups_nxt;
  logic [CNT_W-1:0]           ig_r, ig_nxt;
  logic [CNT_W-1:0]           cg_r, cg_nxt;
  logic                       cv_r, cv_nxt;
  logic [PW-1:0]              rp_r, rp_nxt;
  wvfg_pkg::res_t             res_r, res_nxt;
  logic                       out_valid_r, out_valid_nxt;
  wvfg_pkg::res_t             out_res_r, out_res_nxt;

  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [ROW_W-1:0]           mem_wdata, mem_rdata;

  logic                       fit;
  logic [ROW_W-1:0]           merged_row, fresh_row;

  logic [LW-1:0]              vl_ext, eff_len;
  logic                       in_cmd;
  wvfg_pkg::elem_t            in_elem;
  logic [wvfg_pkg::GRP_W-1:0] in_rg;
  logic [wvfg_pkg::POS_W-1:0] in_rp;
  logic                       in_acc;
  logic [PW-1:0]              wp;
  logic                       rd_go;
  wvfg_pkg::elem_t            lane_val;

  // template rows
  wvfg_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_GROUPS)
  ) u_tmpl_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // row compare and merge against the pending vector
  wvfg_row_unit #(
    .VECTOR_LEN (VECTOR_LEN)
  ) u_row_unit (
    .row_i    (mem_rdata),
    .pend_i   (pend_r),
    .len_i    (eff_len),
    .fit_o    (fit),
    .merged_o (merged_row),
    .fresh_o  (fresh_row)
  );

  // active length: zero acts as one, clipped to the lane count
  assign vl_ext  = LW'(vl_r);
  assign eff_len = (vl_r == '0) ? LW'(1) :
                   (vl_ext > LW'(VECTOR_LEN)) ? LW'(VECTOR_LEN) : vl_ext;

  // input beat fields
  assign in_cmd  = in_tuser;
  assign in_elem = in_tdata[15:0];
  assign in_rg   = in_tdata[21:16];
  assign in_rp   = in_tdata[27:22];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign wp       = (LW'(pos_r) >= eff_len) ? '0 : pos_r;
  assign rd_go    = (ig_r < groups_r);
  assign lane_val = mem_rdata[rp_r*EW +: EW];

  always_comb begin
    state_nxt     = state_r;
    vl_nxt        = vl_r;
    pos_nxt       = pos_r;
    pend_nxt      = pend_r;
    groups_nxt    = groups_r;
    ig_nxt        = ig_r;
    cg_nxt        = cg_r;
    cv_nxt        = cv_r;
    rp_nxt        = rp_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = fresh_row;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == wvfg_pkg::CMD_LOAD) begin
            pend_nxt[wp*EW +: EW] = in_elem;
            if ((LW'(wp) + LW'(1)) >= eff_len) begin
              pos_nxt   = '0;
              ig_nxt    = '0;
              cv_nxt    = 1'b0;
              state_nxt = S_SCAN;
            end else begin
              pos_nxt = wp + 1'b1;
            end
          end else begin
            res_nxt      = '0;
            res_nxt.kind = wvfg_pkg::KIND_READ;
            if ((CMP_W'(in_rg) >= CMP_W'(groups_r)) || (LW'(in_rp) >= eff_len)) begin
              res_nxt.bad = 1'b1;
              state_nxt   = S_RESP;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(in_rg);
              rp_nxt    = PW'(in_rp);
              state_nxt = S_RDWAIT;
            end
          end
        end
      end

      S_SCAN: begin
        // issue one row read per cycle, test it the cycle after
        mem_re    = rd_go;
        mem_raddr = ig_r[AW-1:0];
        cv_nxt    = rd_go;
        cg_nxt    = ig_r;
        if (rd_go) begin
          ig_nxt = ig_r + 1'b1;
        end
        res_nxt      = '0;
        res_nxt.kind = wvfg_pkg::KIND_ASSIGN;
        if (cv_r && fit) begin
          mem_we        = 1'b1;
          mem_waddr     = cg_r[AW-1:0];
          mem_wdata     = merged_row;
          res_nxt.group = wvfg_pkg::GRP_W'(cg_r);
          state_nxt     = S_RESP;
        end else if ((groups_r == '0) || (cv_r && (cg_r + 1'b1) == groups_r)) begin
          // nothing fits: open a group or report full
          if (groups_r == CNT_W'(MAX_GROUPS)) begin
            res_nxt.full = 1'b1;
          end else begin
            mem_we         = 1'b1;
            mem_waddr      = groups_r[AW-1:0];
            mem_wdata      = fresh_row;
            groups_nxt     = groups_r + 1'b1;
            res_nxt.group  = wvfg_pkg::GRP_W'(groups_r);
            res_nxt.opened = 1'b1;
          end
          state_nxt = S_RESP;
        end
      end

      S_RDWAIT: begin
        res_nxt.value = (lane_val == wvfg_pkg::WILDCARD) ? '0 : lane_val;
        state_nxt     = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // length write drops a partial vector
    if (cfg_wr_en) begin
      vl_nxt  = cfg_wr_data;
      pos_nxt = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vl_r        <= wvfg_pkg::LENGTH_AT_RESET;
      pos_r       <= '0;
      groups_r    <= '0;
      ig_r        <= '0;
      cv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vl_r        <= vl_nxt;
      pos_r       <= pos_nxt;
      groups_r    <= groups_nxt;
      ig_r        <= ig_nxt;
      cv_r        <= cv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pend_r    <= pend_nxt;
    cg_r      <= cg_nxt;
    rp_r      <= rp_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {7'b0, out_res_r.bad, out_res_r.value, out_res_r.full,
                       out_res_r.opened, out_res_r.group};

  // group count never runs past the table
  `WVFG_ASSERT_NEVER(a_groups_bound, groups_r > CNT_W'(MAX_GROUPS), "group count overflow")
  // a write-back never collides with a row read in flight
  `WVFG_ASSERT_IMPLY(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "row read/write clash")
  // full is only reported once every slot is taken
  `WVFG_ASSERT_IMPLY(a_full_real, out_valid_r && out_res_r.full, groups_r == CNT_W'(MAX_GROUPS), "false table full")

endmodule

@@ verif/tb_wildcard_vector_first_fit_grouper.sv @@
`timescale 1ns / 100ps

module tb_wildcard_vector_first_fit_grouper;

  localparam int unsigned GROUP_MAX     = 64;
  localparam int unsigned VEC_MAX       = 48;
  localparam int unsigned RANDOM_ITEMS  = 1100;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  // one input beat before packing
  typedef struct {
    logic                       cmd;
    logic [15:0]                value;
    logic [wvfg_pkg::GRP_W-1:0] rgroup;
    logic [wvfg_pkg::POS_W-1:0] rpos;
  } request_t;

  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           cfg_wr_en   = 1'b0;
  logic [wvfg_pkg::CFG_W-1:0]     cfg_wr_data = '0;
  logic                           in_tvalid   = 1'b0;
  logic                           in_tready;
  logic [wvfg_pkg::TDATA_W-1:0]   in_tdata    = '0;
  logic                           in_tuser    = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready  = 1'b0;
  logic [wvfg_pkg::TDATA_W-1:0]   out_tdata;
  logic                           out_tuser;

  // grouping state as the block should hold it
  logic [15:0]                    vector_elems  [VEC_MAX];
  logic [15:0]                    template_rows [GROUP_MAX][VEC_MAX];
  int unsigned                    groups_used = 0;
  int unsigned                    load_pos    = 0;
  logic [wvfg_pkg::CFG_W-1:0]     len_setting = wvfg_pkg::LENGTH_AT_RESET;

  wvfg_pkg::res_t                 due_results [$];
  int unsigned                    fail_count      = 0;
  int unsigned                    items_sent      = 0;
  int unsigned                    cycle_count     = 0;
  int                             hold_off_cycles = 0;
  bit                             source_idling   = 1'b0;
  bit                             sink_idling     = 1'b0;

  wildcard_vector_first_fit_grouper #(
    .MAX_GROUPS (GROUP_MAX),
    .VECTOR_LEN (VEC_MAX)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // zero-length and over-long settings are clamped
  function automatic int unsigned active_len();
    if (len_setting == 0) return 1;
    if (len_setting > VEC_MAX) return VEC_MAX;
    return 32'(len_setting);
  endfunction

  // expected result for one accepted beat; returns 0 when none is due
  function automatic bit predict_grouping(input request_t req, output wvfg_pkg::res_t res);
    int unsigned len;
    bit          fit;
    len = active_len();
    res = '0;
    res.kind = req.cmd;
    if (req.cmd == wvfg_pkg::CMD_READ) begin
      if (req.rgroup >= groups_used || req.rpos >= len) begin
        res.bad = 1'b1;
      end else if (template_rows[req.rgroup][req.rpos] != wvfg_pkg::WILDCARD) begin
        res.value = template_rows[req.rgroup][req.rpos];
      end
      return 1'b1;
    end
    if (load_pos >= len) load_pos = 0;
    vector_elems[load_pos] = req.value;
    load_pos++;
    if (load_pos < len) return 1'b0;
    load_pos = 0;
    // first fit from group 0, sharpening wildcards of the template
    for (int unsigned g = 0; g < groups_used; g++) begin
      fit = 1'b1;
      for (int unsigned i = 0; i < len; i++) begin
        if (template_rows[g][i] != wvfg_pkg::WILDCARD &&
            vector_elems[i] != wvfg_pkg::WILDCARD &&
            template_rows[g][i] != vector_elems[i]) fit = 1'b0;
      end
      if (fit) begin
        for (int unsigned i = 0; i < len; i++) begin
          if (template_rows[g][i] == wvfg_pkg::WILDCARD) template_rows[g][i] = vector_elems[i];
        end
        res.group = wvfg_pkg::GRP_W'(g);
        return 1'b1;
      end
    end
    if (groups_used >= GROUP_MAX) begin
      res.full = 1'b1;
      return 1'b1;
    end
    for (int unsigned i = 0; i < VEC_MAX; i++) begin
      template_rows[groups_used][i] = (i < len) ? vector_elems[i] : wvfg_pkg::WILDCARD;
    end
    res.group  = wvfg_pkg::GRP_W'(groups_used);
    res.opened = 1'b1;
    groups_used++;
    return 1'b1;
  endfunction

  // per-beat wait, with occasional switches between busy and quiet stretches
  function automatic int draw_gap(inout bit idling);
    if ($urandom_range(0, 39) == 0) idling = !idling;
    return idling ? $urandom_range(0, 10) : 0;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // sends one beat, waits for the handshake and records what it should cause
  task automatic send_request(input request_t req);
    int             gap;
    wvfg_pkg::res_t res;
    gap = draw_gap(source_idling);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req.cmd;
    in_tdata  <= {4'b0, req.rpos, req.rgroup, req.value};
    do @(posedge clk); while (!in_tready);
    if (predict_grouping(req, res)) due_results.insert(due_results.size(), res);
    items_sent++;
  endtask

  task automatic send_load(input logic [15:0] value);
    request_t req;
    req.cmd    = wvfg_pkg::CMD_LOAD;
    req.value  = value;
    req.rgroup = wvfg_pkg::GRP_W'($urandom);
    req.rpos   = wvfg_pkg::POS_W'($urandom);
    send_request(req);
  endtask

  task automatic send_read(input logic [wvfg_pkg::GRP_W-1:0] grp,
                           input logic [wvfg_pkg::POS_W-1:0] pos);
    request_t req;
    req.cmd    = wvfg_pkg::CMD_READ;
    req.value  = 16'($urandom);
    req.rgroup = grp;
    req.rpos   = pos;
    send_request(req);
  endtask

  // mostly reads of groups and positions in use, some anywhere
  function automatic request_t random_read();
    request_t req;
    req.cmd    = wvfg_pkg::CMD_READ;
    req.value  = 16'($urandom);
    req.rgroup = (groups_used > 0 && $urandom_range(0, 3) != 0) ?
                 wvfg_pkg::GRP_W'($urandom_range(0, groups_used - 1)) :
                 wvfg_pkg::GRP_W'($urandom_range(0, 63));
    req.rpos   = ($urandom_range(0, 3) != 0) ?
                 wvfg_pkg::POS_W'($urandom_range(0, active_len() - 1)) :
                 wvfg_pkg::POS_W'($urandom_range(0, 63));
    return req;
  endfunction

  // element near the phase motif, so that vectors often fit each other
  function automatic logic [15:0] pick_element(input logic [15:0] motif_val,
                                               input int alphabet, input int wild_pct);
    int r;
    if ($urandom_range(0, 99) < wild_pct) return wvfg_pkg::WILDCARD;
    r = $urandom_range(0, 99);
    if (r < 70) return motif_val;
    if (r < 85) return 16'($urandom_range(0, alphabet - 1));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // stop offering, wait for every due result, then let a scan in flight finish
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [wvfg_pkg::CFG_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    len_setting = value;
    load_pos    = 0;
  endtask

  // reads of an empty table, partial load at the reset length
  task automatic test_empty_reads();
    send_read(6'd0, 6'd0);
    send_read(6'd63, 6'd63);
    send_read(6'd0, wvfg_pkg::POS_W'(VEC_MAX - 1));
    send_load(wvfg_pkg::WILDCARD);
  endtask

  // opening, fitting, sharpening, leftover wildcards, length clamping and drop
  task automatic test_merge_rules();
    write_length(6'd2);
    send_load(16'd0);               send_load(wvfg_pkg::WILDCARD);
    send_load(wvfg_pkg::WILDCARD);  send_load(wvfg_pkg::WILDCARD);
    send_load(16'd0);               send_load(16'd5);
    send_load(16'd1);               send_load(wvfg_pkg::WILDCARD);
    send_read(6'd0, 6'd1);
    send_read(6'd1, 6'd1);
    send_read(6'd0, 6'd2);
    send_read(6'd2, 6'd0);
    // a half-loaded vector is thrown away by the length write
    send_load(16'd7);
    write_length(6'd3);
    send_read(6'd0, 6'd2);
    send_load(16'd0); send_load(16'd5); send_load(16'd9);
    send_read(6'd0, 6'd2);
    // zero acts as one element
    write_length(6'd0);
    send_load(16'd42);
    send_load(16'hFFFE);
    send_read(6'd2, 6'd1);
    // over-long acts as the full vector
    write_length(6'd63);
    send_read(6'd2, wvfg_pkg::POS_W'(VEC_MAX - 1));
    send_read(6'd63, 6'd63);
    send_read(6'd0, wvfg_pkg::POS_W'(VEC_MAX));
  endtask

  // long result stall with the source still pushing, then a full pause
  task automatic test_output_backpressure();
    write_length(6'd2);
    hold_off_cycles = 300;
    repeat (60) begin
      if ($urandom_range(0, 1) != 0) send_request(random_read());
      else send_load(pick_element(16'd0, 3, 30));
    end
    drain_results();
  endtask

  // phases of random length, alphabet and wildcard density
  task automatic test_random_traffic();
    logic [15:0] motif [VEC_MAX];
    int unsigned stop_at;
    int          phase_items;
    int          alphabet;
    int          wild_pct;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 19))
        0:       write_length(6'd48);
        1:       write_length(6'd63);
        2:       write_length(6'd0);
        3:       write_length(6'd1);
        default: write_length(wvfg_pkg::CFG_W'($urandom_range(2, 8)));
      endcase
      alphabet = $urandom_range(1, 6);
      wild_pct = $urandom_range(0, 60);
      foreach (motif[i]) motif[i] = 16'($urandom_range(0, alphabet - 1));
      phase_items = (active_len() > 8) ? $urandom_range(100, 200) : $urandom_range(20, 100);
      // a phase may end mid-vector, which the next length write drops
      repeat (phase_items) begin
        if ($urandom_range(0, 99) < 15) send_request(random_read());
        else send_load(pick_element(motif[load_pos], alphabet, wild_pct));
      end
    end
  endtask

  // single-element vectors of scattered values until no slot is left
  task automatic test_table_full();
    int tries;
    write_length(6'd1);
    tries = 0;
    while (groups_used < GROUP_MAX && tries < 400) begin
      send_load(16'($urandom_range(0, 16'hFFFE)));
      tries++;
    end
    repeat (4) send_load(16'($urandom_range(0, 16'hFFFE)));
    send_read(wvfg_pkg::GRP_W'(GROUP_MAX - 1), 6'd0);
    send_read(6'd0, 6'd0);
    send_read(wvfg_pkg::GRP_W'(GROUP_MAX - 1), 6'd1);
    drain_results();
  endtask

  // result side: random stalls per beat, long hold-off on request
  initial begin : result_sink
    int gap;
    gap = 0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
        hold_off_cycles--;
      end else if (out_tvalid && out_tready) begin
        gap = draw_gap(sink_idling);
        out_tready <= (gap == 0);
      end else if (gap > 0) begin
        gap--;
        out_tready <= (gap == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    wvfg_pkg::res_t got;
    wvfg_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind   = out_tuser;
      got.group  = out_tdata[5:0];
      got.opened = out_tdata[6];
      got.full   = out_tdata[7];
      got.value  = out_tdata[23:8];
      got.bad    = out_tdata[24];
      if (due_results.size() == 0) begin
        report_mismatch("result beat with nothing due, tdata", longint'(out_tdata), '0);
      end else begin
        want = due_results.pop_front();
        if (got.kind !== want.kind)
          report_mismatch("result_kind", longint'(got.kind), longint'(want.kind));
        if (got.group !== want.group)
          report_mismatch("group_index", longint'(got.group), longint'(want.group));
        if (got.opened !== want.opened)
          report_mismatch("opened_new_group", longint'(got.opened), longint'(want.opened));
        if (got.full !== want.full)
          report_mismatch("table_full", longint'(got.full), longint'(want.full));
        if (got.value !== want.value)
          report_mismatch("read_value", longint'(got.value), longint'(want.value));
        if (got.bad !== want.bad)
          report_mismatch("bad_read", longint'(got.bad), longint'(want.bad));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("wildcard_vector_first_fit_grouper: mismatch");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_reads();
    test_merge_rules();
    test_output_backpressure();
    test_random_traffic();
    test_table_full();
    drain_results();
    if (fail_count == 0) begin
      $display("wildcard_vector_first_fit_grouper: match");
    end else begin
      $display("wildcard_vector_first_fit_grouper: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/wvfg_pkg.sv
sv/wvfg_ram.sv
sv/wvfg_row_unit.sv
sv/wildcard_vector_first_fit_grouper.sv
verif/tb_wildcard_vector_first_fit_grouper.sv
